### rtl/sac_pkg.sv
package sac_pkg;
   localparam int MAX_PIXELS  = 65536;
   localparam int MAX_CLASSES = 256;
   localparam int PIX_W = 16;
   localparam int CLS_W = 8;
   localparam int REQ_DATA_W = 80;   // channel, pixel_index, score, palette_color
   localparam int RSP_DATA_W = 48;   // out_pixel, class_index, color

   localparam logic CMD_SCORE   = 1'b0;
   localparam logic CMD_PALETTE = 1'b1;

   localparam logic [0:0] REG_NUM_CLASSES = 1'd0;
   localparam logic [0:0] REG_NUM_PIXELS  = 1'd1;

   // strict IEEE greater-than; NaN on either side gives false, +0 == -0
   function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
      logic a_nan, b_nan, a_zero, b_zero;
      a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      if (a_nan || b_nan)        fp_gt = 1'b0;
      else if (a_zero && b_zero) fp_gt = 1'b0;
      else if (a[31] != b[31])   fp_gt = b[31];
      else if (!a[31])           fp_gt = a[30:0] > b[30:0];
      else                       fp_gt = a[30:0] < b[30:0];
   endfunction
endpackage

### rtl/sac_best_ram.sv
module sac_best_ram import sac_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PIX_W-1:0] wr_addr,
   input  logic [39:0]      wr_data,
   input  logic [PIX_W-1:0] rd_addr,
   output logic [39:0]      rd_data
);
   logic [39:0] mem [MAX_PIXELS];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/segmentation_argmax_colorizer.sv
// Per-pixel argmax colorizer for segmentation score planes.
// req_ channel: one score sample or palette write per transfer; tuser = command
//   (0 score, 1 palette write). Scores arrive channel-major over num_pixels pixels.
// rsp_ channel: one transfer per pixel when its last class channel arrives:
//   pixel, winning class and 24-bit palette color; tlast marks the last pixel.
// csr_ port: register 0 num_classes at 0x0, register 1 num_pixels at 0x4.
// Throughput: one item per cycle while the output buffer is not full. Pipeline:
// best score/class memory read issued on the input transfer, compare and
// write-back in stage 1, palette read into stage 2, then the output buffer.
// A write-back to a pixel still in flight is forwarded to the following read.
// Reset clears control only; the memories hold garbage until written
// (channel 0 of a frame initializes each pixel).
// When rsp_tready is low the pipeline keeps filling a two-entry output buffer;
// req_tready stays high until both entries are held, then drops.
module segmentation_argmax_colorizer import sac_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // channel, pixel_index, score, palette_color
   input  logic                  req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_pixel, class_index, color
   output logic                  rsp_tlast,  // last_pixel
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   logic [8:0]  ncls_ff;
   logic [16:0] npix_ff;
   logic [8:0]  eff_cls;
   logic [16:0] eff_pix;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         ncls_ff <= 9'd2;
         npix_ff <= 17'd65536;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_NUM_CLASSES: ncls_ff <= csr_pwdata[8:0];
            REG_NUM_PIXELS:  npix_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr[2])
         REG_NUM_CLASSES: csr_prdata = {23'd0, ncls_ff};
         REG_NUM_PIXELS:  csr_prdata = {15'd0, npix_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end
   assign eff_cls = (ncls_ff == 9'd0) ? 9'd1 : (ncls_ff > 9'd256 ? 9'd256 : ncls_ff);
   assign eff_pix = (npix_ff == 17'd0) ? 17'd1
                    : (npix_ff > 17'd65536 ? 17'd65536 : npix_ff);

   // input decode
   logic [CLS_W-1:0] in_ch;
   logic [PIX_W-1:0] in_pix;
   logic [31:0]      in_score;
   logic [23:0]      in_color;
   assign in_ch    = req_tdata[7:0];
   assign in_pix   = req_tdata[23:8];
   assign in_score = req_tdata[55:24];
   assign in_color = req_tdata[79:56];

   logic adv, acc;
   logic s1_v_ff, s1_last_ff, s1_first_ff;
   logic [CLS_W-1:0] s1_ch_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [31:0]      s1_score_ff;
   logic s2_v_ff, s2_tl_ff;
   logic [PIX_W-1:0] s2_pix_ff;
   logic [CLS_W-1:0] s2_cls_ff;
   logic [23:0] pal_rd_ff;
   logic [23:0] palette [MAX_CLASSES];

   assign acc = req_tvalid && req_tready;

   // stage 1 capture
   logic in_ok;
   assign in_ok = (req_tuser == CMD_SCORE) && ({1'b0, in_ch} < eff_cls)
                  && ({1'b0, in_pix} < eff_pix);
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= acc && in_ok;
      if (adv) begin
         s1_ch_ff    <= in_ch;
         s1_pix_ff   <= in_pix;
         s1_score_ff <= in_score;
         s1_first_ff <= (in_ch == 8'd0);
         s1_last_ff  <= ({1'b0, in_ch} == eff_cls - 9'd1);
      end
      if (acc && req_tuser == CMD_PALETTE) palette[in_ch] <= in_color;
   end

   // best memory: {class, score}
   logic [39:0] rd_data, wb_data;
   logic wb_en;
   logic [PIX_W-1:0] rd_addr;
   logic byp_ff;
   logic [39:0] byp_data_ff;
   assign rd_addr = adv ? in_pix : s1_pix_ff;
   sac_best_ram u_ram (
      .clock, .wr_en(wb_en), .wr_addr(s1_pix_ff), .wr_data(wb_data),
      .rd_addr, .rd_data
   );
   // forward a write to the address being read in the same cycle
   always_ff @(posedge clock) begin
      byp_ff      <= wb_en && (s1_pix_ff == rd_addr);
      byp_data_ff <= wb_data;
   end

   logic [39:0] cur;
   logic take;
   assign cur  = byp_ff ? byp_data_ff : rd_data;
   assign take = s1_first_ff || fp_gt(s1_score_ff, cur[31:0]);
   assign wb_data = take ? {s1_ch_ff, s1_score_ff} : cur;
   assign wb_en = adv && s1_v_ff;

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= s1_v_ff && s1_last_ff;
      if (adv) begin
         s2_pix_ff <= s1_pix_ff;
         s2_cls_ff <= wb_data[39:32];
         s2_tl_ff  <= ({1'b0, s1_pix_ff} == eff_pix - 17'd1);
         pal_rd_ff <= palette[wb_data[39:32]];
      end
   end

   // two-entry output queue
   logic [48:0] q_ff [2];
   logic [1:0]  cnt_ff;
   logic        rd_ff;
   logic push, pop;
   assign pop  = rsp_tvalid && rsp_tready;
   assign adv  = (cnt_ff != 2'd2);
   assign push = adv && s2_v_ff;
   assign req_tready = adv;
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign {rsp_tlast, rsp_tdata} = q_ff[rd_ff];
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
         if (pop) rd_ff <= ~rd_ff;
      end
      if (push) q_ff[rd_ff ^ cnt_ff[0]] <= {s2_tl_ff, pal_rd_ff, s2_cls_ff, s2_pix_ff};
   end
endmodule

### rtl/sac_checker.sv
module sac_checker import sac_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  csr_pready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed under stall");
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");
   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind segmentation_argmax_colorizer sac_checker u_sac_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast, .csr_pready
);
